>>> design/swsm_pkg.sv
`default_nettype none

package swsm_pkg;

    localparam int NUM_SLOTS       = 9;
    localparam int SLOT_W          = 4;
    localparam int POS_W           = 32;
    localparam int SIDE_W          = 24;
    localparam int OUT_W           = 32;
    localparam int DIV_STEPS       = 32;
    localparam int DIV_CNT_W       = $clog2(DIV_STEPS);
    localparam int COORD_WIDTH_DEF = 32;

    localparam logic [SIDE_W-1:0] SIDE_RESET = 24'd4096;

    localparam logic ACT_SWAP = 1'b0;
    localparam logic ACT_LOAD = 1'b1;

    typedef enum logic [6:0] {
        ST_IDLE  = 7'b0000001,
        ST_DIV   = 7'b0000010,
        ST_LATCH = 7'b0000100,
        ST_CHECK = 7'b0001000,
        ST_SWAP  = 7'b0010000,
        ST_SCAN  = 7'b0100000,
        ST_EMIT  = 7'b1000000
    } t_state;

    typedef struct packed {
        logic div_start;
        logic latch;
        logic swap_step;
        logic scan_step;
        logic emit_step;
    } t_cmd;

    typedef struct packed {
        logic div_done;
        logic same;
        logic adv;
        logic idx_last;
    } t_status;

endpackage

`default_nettype wire

>>> design/swsm_div.sv
`default_nettype none

module swsm_div (
    input  wire logic                               i_clk,
    input  wire logic                               i_rst_n,
    input  wire logic                               i_start,
    input  wire logic signed [swsm_pkg::POS_W-1:0]  i_dividend,
    input  wire logic        [swsm_pkg::SIDE_W-1:0] i_divisor,
    output logic                                    o_done,
    output logic signed      [swsm_pkg::POS_W-1:0]  o_quot
);
    import swsm_pkg::*;

    logic                 r_busy;
    logic                 r_done;
    logic [DIV_CNT_W-1:0] r_cnt;
    logic [POS_W-1:0]     r_dvd;
    logic [SIDE_W-1:0]    r_rem;
    logic [SIDE_W-1:0]    r_dsr;
    logic                 r_neg;

    logic [SIDE_W:0]      n_trial;
    logic                 n_ge;
    logic [POS_W-1:0]     n_mag;

    always_comb begin
        n_trial = {r_rem, r_dvd[POS_W-1]};
        n_ge    = (n_trial >= {1'b0, r_dsr});
        n_mag   = i_dividend[POS_W-1] ? POS_W'(-i_dividend) : POS_W'(i_dividend);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= '0;
            end else if (r_busy) begin
                r_cnt <= r_cnt + 1'b1;
                if (r_cnt == DIV_CNT_W'(DIV_STEPS - 1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    // restoring divide on the magnitude, one quotient bit a cycle
    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_dvd <= n_mag;
            r_rem <= '0;
            r_dsr <= i_divisor;
            r_neg <= i_dividend[POS_W-1];
        end else if (r_busy) begin
            r_dvd <= {r_dvd[POS_W-2:0], n_ge};
            r_rem <= n_ge ? SIDE_W'(n_trial - {1'b0, r_dsr}) : n_trial[SIDE_W-1:0];
        end
    end

    // floor: negative with a remainder is -(q+1), which is ~q
    always_comb begin
        if (!r_neg) begin
            o_quot = $signed(r_dvd);
        end else if (r_rem != '0) begin
            o_quot = $signed(~r_dvd);
        end else begin
            o_quot = $signed(POS_W'(-r_dvd));
        end
    end

    assign o_done = r_done;

endmodule

`default_nettype wire

>>> design/swsm_dp.sv
`default_nettype none

module swsm_dp #(
    parameter int COORD_WIDTH = swsm_pkg::COORD_WIDTH_DEF
) (
    input  wire logic                               i_clk,
    input  wire logic                               i_rst_n,
    input  wire swsm_pkg::t_cmd                     i_cmd,
    output swsm_pkg::t_status                       o_st,
    input  wire logic signed [swsm_pkg::POS_W-1:0]  i_pos_x,
    input  wire logic signed [swsm_pkg::POS_W-1:0]  i_pos_z,
    input  wire logic                               i_cfg_valid,
    output logic                                    o_cfg_ready,
    input  wire logic        [swsm_pkg::SIDE_W-1:0] i_cfg_sector_side,
    output logic                                    o_out_valid,
    input  wire logic                               i_out_ready,
    output logic                                    o_action,
    output logic             [swsm_pkg::SLOT_W-1:0] o_slot_a,
    output logic             [swsm_pkg::SLOT_W-1:0] o_slot_b,
    output logic signed      [swsm_pkg::OUT_W-1:0]  o_sector_x,
    output logic signed      [swsm_pkg::OUT_W-1:0]  o_sector_y,
    output logic                                    o_last
);
    import swsm_pkg::*;

    logic [SIDE_W-1:0]      r_side;
    logic [COORD_WIDTH-1:0] r_cx;
    logic [COORD_WIDTH-1:0] r_cy;
    logic [COORD_WIDTH-1:0] r_cur_x;
    logic [COORD_WIDTH-1:0] r_cur_y;
    logic                   r_cur_valid;

    logic                   r_slot_valid [NUM_SLOTS];
    logic [COORD_WIDTH-1:0] r_slot_x     [NUM_SLOTS];
    logic [COORD_WIDTH-1:0] r_slot_y     [NUM_SLOTS];
    logic [NUM_SLOTS-1:0]   r_need;

    logic [SLOT_W-1:0]      r_idx;
    logic [1:0]             r_col;
    logic [1:0]             r_row;

    logic                   r_out_valid;
    logic                   r_out_action;
    logic [SLOT_W-1:0]      r_out_slot_a;
    logic [SLOT_W-1:0]      r_out_slot_b;
    logic [OUT_W-1:0]       r_out_x;
    logic [OUT_W-1:0]       r_out_y;
    logic                   r_out_last;

    logic [SIDE_W-1:0]      side_eff;
    logic                   div_done_x;
    logic                   div_done_y;
    logic signed [POS_W-1:0] quot_x;
    logic signed [POS_W-1:0] quot_y;

    logic [COORD_WIDTH-1:0] off_x;
    logic [COORD_WIDTH-1:0] off_y;
    logic [COORD_WIDTH-1:0] want_x;
    logic [COORD_WIDTH-1:0] want_y;
    logic [NUM_SLOTS-1:0]   match;
    logic [SLOT_W-1:0]      found;
    logic                   swap_need;
    logic                   out_free;
    logic                   swap_do;
    logic                   load_do;
    logic                   idx_last;
    logic                   adv;
    logic [NUM_SLOTS-1:0]   need_rest;
    logic                   load_last;
    logic                   rd_valid;
    logic [COORD_WIDTH-1:0] rd_x;
    logic [COORD_WIDTH-1:0] rd_y;

    assign side_eff = (r_side == '0) ? SIDE_W'(1) : r_side;

    swsm_div u_div_x (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (i_cmd.div_start),
        .i_dividend (i_pos_x),
        .i_divisor  (side_eff),
        .o_done     (div_done_x),
        .o_quot     (quot_x)
    );

    swsm_div u_div_z (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (i_cmd.div_start),
        .i_dividend (i_pos_z),
        .i_divisor  (side_eff),
        .o_done     (div_done_y),
        .o_quot     (quot_y)
    );

    // wanted sector of the current slot: center plus -1, 0 or +1
    always_comb begin
        off_x  = (r_col == 2'd0) ? '1 : COORD_WIDTH'(r_col == 2'd2);
        off_y  = (r_row == 2'd0) ? '1 : COORD_WIDTH'(r_row == 2'd2);
        want_x = r_cx + off_x;
        want_y = r_cy + off_y;
    end

    always_comb begin
        for (int k = 0; k < NUM_SLOTS; k++) begin
            match[k] = r_slot_valid[k] && (r_slot_x[k] == want_x) && (r_slot_y[k] == want_y);
        end
    end

    // lowest matching slot wins
    always_comb begin
        found = '0;
        for (int k = NUM_SLOTS - 1; k >= 0; k--) begin
            if (match[k]) begin
                found = SLOT_W'(k);
            end
        end
    end

    always_comb begin
        rd_valid  = r_slot_valid[r_idx];
        rd_x      = r_slot_x[r_idx];
        rd_y      = r_slot_y[r_idx];
        out_free  = !r_out_valid || i_out_ready;
        swap_need = (|match) && (found != r_idx);
        swap_do   = i_cmd.swap_step && swap_need && out_free;
        load_do   = i_cmd.emit_step && r_need[r_idx] && out_free;
        idx_last  = (r_idx == SLOT_W'(NUM_SLOTS - 1));
        need_rest = r_need >> r_idx;
        load_last = (need_rest[NUM_SLOTS-1:1] == '0);
        adv       = (i_cmd.swap_step && (!swap_need || out_free))
                 || i_cmd.scan_step
                 || (i_cmd.emit_step && (!r_need[r_idx] || out_free));
    end

    assign o_st.div_done = div_done_x && div_done_y;
    assign o_st.same     = r_cur_valid && (r_cx == r_cur_x) && (r_cy == r_cur_y);
    assign o_st.adv      = adv;
    assign o_st.idx_last = idx_last;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_side      <= SIDE_RESET;
            r_cur_x     <= '0;
            r_cur_y     <= '0;
            r_cur_valid <= 1'b0;
            r_idx       <= '0;
            r_col       <= '0;
            r_row       <= '0;
        end else begin
            if (i_cfg_valid) begin
                r_side <= i_cfg_sector_side;
            end
            if (i_cmd.latch) begin
                r_idx <= '0;
                r_col <= '0;
                r_row <= '0;
            end else if (adv) begin
                if (idx_last) begin
                    r_idx <= '0;
                    r_col <= '0;
                    r_row <= '0;
                end else begin
                    r_idx <= r_idx + 1'b1;
                    if (r_col == 2'd2) begin
                        r_col <= '0;
                        r_row <= r_row + 1'b1;
                    end else begin
                        r_col <= r_col + 1'b1;
                    end
                end
            end
            if (i_cmd.emit_step && adv && idx_last) begin
                r_cur_x     <= r_cx;
                r_cur_y     <= r_cy;
                r_cur_valid <= 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.latch) begin
            r_cx <= COORD_WIDTH'(quot_x);
            r_cy <= COORD_WIDTH'(quot_y);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int k = 0; k < NUM_SLOTS; k++) begin
                r_slot_valid[k] <= 1'b0;
            end
        end else if (swap_do) begin
            r_slot_valid[r_idx] <= 1'b1;
            r_slot_valid[found] <= rd_valid;
        end else if (i_cmd.scan_step) begin
            r_slot_valid[r_idx] <= 1'b1;
        end
    end

    // the found slot holds the wanted sector, so only the displaced one is read
    always_ff @(posedge i_clk) begin
        if (swap_do) begin
            r_slot_x[r_idx] <= want_x;
            r_slot_y[r_idx] <= want_y;
            r_slot_x[found] <= rd_x;
            r_slot_y[found] <= rd_y;
        end else if (i_cmd.scan_step) begin
            r_slot_x[r_idx]  <= want_x;
            r_slot_y[r_idx]  <= want_y;
            r_need[r_idx]    <= !match[r_idx];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (swap_do || load_do) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (swap_do) begin
            r_out_action <= ACT_SWAP;
            r_out_slot_a <= r_idx;
            r_out_slot_b <= found;
            r_out_x      <= '0;
            r_out_y      <= '0;
            r_out_last   <= 1'b0;
        end else if (load_do) begin
            r_out_action <= ACT_LOAD;
            r_out_slot_a <= r_idx;
            r_out_slot_b <= '0;
            r_out_x      <= OUT_W'(want_x);
            r_out_y      <= OUT_W'(want_y);
            r_out_last   <= load_last;
        end
    end

    assign o_cfg_ready = 1'b1;
    assign o_out_valid = r_out_valid;
    assign o_action    = r_out_action;
    assign o_slot_a    = r_out_slot_a;
    assign o_slot_b    = r_out_slot_b;
    assign o_sector_x  = $signed(r_out_x);
    assign o_sector_y  = $signed(r_out_y);
    assign o_last      = r_out_last;

`ifndef SYNTHESIS
    a_idx_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_idx <= SLOT_W'(NUM_SLOTS - 1))
        else $error("slot index out of range");

    a_swap_distinct: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        swap_do |-> (found != r_idx) && match[found])
        else $error("swap between a slot and itself");

    a_last_commits: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_cmd.emit_step && adv && idx_last) |=> r_cur_valid && (r_cur_x == $past(r_cx)))
        else $error("emit phase ended without window commit");

    a_single_step: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $countones({i_cmd.swap_step, i_cmd.scan_step, i_cmd.emit_step}) <= 1)
        else $error("two phases stepping at once");
`endif

endmodule

`default_nettype wire

>>> design/swsm_ctrl.sv
`default_nettype none

module swsm_ctrl (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              i_in_valid,
    output logic                   o_in_ready,
    input  wire swsm_pkg::t_status i_st,
    output swsm_pkg::t_cmd         o_cmd
);
    import swsm_pkg::*;

    t_state r_state;
    t_state n_state;

    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        unique case (r_state)
            ST_IDLE: begin
                o_cmd.div_start = i_in_valid;
                if (i_in_valid) begin
                    n_state = ST_DIV;
                end
            end
            ST_DIV: begin
                if (i_st.div_done) begin
                    n_state = ST_LATCH;
                end
            end
            ST_LATCH: begin
                o_cmd.latch = 1'b1;
                n_state     = ST_CHECK;
            end
            ST_CHECK: begin
                n_state = i_st.same ? ST_IDLE : ST_SWAP;
            end
            ST_SWAP: begin
                o_cmd.swap_step = 1'b1;
                if (i_st.adv && i_st.idx_last) begin
                    n_state = ST_SCAN;
                end
            end
            ST_SCAN: begin
                o_cmd.scan_step = 1'b1;
                if (i_st.idx_last) begin
                    n_state = ST_EMIT;
                end
            end
            ST_EMIT: begin
                o_cmd.emit_step = 1'b1;
                if (i_st.adv && i_st.idx_last) begin
                    n_state = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    assign o_in_ready = (r_state == ST_IDLE);

`ifndef SYNTHESIS
    a_state_onehot: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $onehot(r_state))
        else $error("state register not one-hot");

    a_start_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cmd.div_start |=> (r_state == ST_DIV))
        else $error("divide started outside an accept");

    a_done_in_div: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_st.div_done |-> (r_state == ST_DIV))
        else $error("divide finished while not waiting for it");
`endif

endmodule

`default_nettype wire

>>> design/sector_window_slot_manager_core.sv
// an item is taken only in idle; a serial divide, a latch and a check follow; an unchanged sector ends there
// re-fit: a slot search for each of the nine slots, then slot checks, then loads, plus output stalls
// the first result is the swap of the lowest slot that needs one, else the first load
// the block takes no new item until it is back in idle, as it has one shared slot counter
//   and two bit-serial dividers
// reset (synchronous, active low): slots empty, no current sector, side 4096
`default_nettype none

module sector_window_slot_manager_core #(
    parameter int COORD_WIDTH = swsm_pkg::COORD_WIDTH_DEF
) (
    input  wire logic                               i_clk,
    input  wire logic                               i_rst_n,
    input  wire logic                               i_in_valid,
    output logic                                    o_in_ready,
    input  wire logic signed [swsm_pkg::POS_W-1:0]  i_pos_x,
    input  wire logic signed [swsm_pkg::POS_W-1:0]  i_pos_z,
    input  wire logic                               i_cfg_valid,
    output logic                                    o_cfg_ready,
    input  wire logic        [swsm_pkg::SIDE_W-1:0] i_cfg_sector_side,
    output logic                                    o_out_valid,
    input  wire logic                               i_out_ready,
    output logic                                    o_action,
    output logic             [swsm_pkg::SLOT_W-1:0] o_slot_a,
    output logic             [swsm_pkg::SLOT_W-1:0] o_slot_b,
    output logic signed      [swsm_pkg::OUT_W-1:0]  o_sector_x,
    output logic signed      [swsm_pkg::OUT_W-1:0]  o_sector_y,
    output logic                                    o_last
);
    import swsm_pkg::*;

    t_cmd    cmd;
    t_status st;

    swsm_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_ready (o_in_ready),
        .i_st       (st),
        .o_cmd      (cmd)
    );

    swsm_dp #(
        .COORD_WIDTH (COORD_WIDTH)
    ) u_dp (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .i_cmd             (cmd),
        .o_st              (st),
        .i_pos_x           (i_pos_x),
        .i_pos_z           (i_pos_z),
        .i_cfg_valid       (i_cfg_valid),
        .o_cfg_ready       (o_cfg_ready),
        .i_cfg_sector_side (i_cfg_sector_side),
        .o_out_valid       (o_out_valid),
        .i_out_ready       (i_out_ready),
        .o_action          (o_action),
        .o_slot_a          (o_slot_a),
        .o_slot_b          (o_slot_b),
        .o_sector_x        (o_sector_x),
        .o_sector_y        (o_sector_y),
        .o_last            (o_last)
    );

endmodule

`default_nettype wire

>>> tb/tb_sector_window_slot_manager_core.sv
`timescale 1ns / 100ps

module tb_sector_window_slot_manager_core;
    import swsm_pkg::*;

    localparam int CYCLE_LIMIT   = 1_000_000;
    localparam int SETTLE_CYCLES = 80;
    localparam int PHASE_ITEMS   = 165;
    localparam int MAX_PRINTS    = 50;
    localparam int DIR_ROWS      = 25;

    typedef struct packed {
        logic              action;
        logic [SLOT_W-1:0] slot_a;
        logic [SLOT_W-1:0] slot_b;
        logic [OUT_W-1:0]  sector_x;
        logic [OUT_W-1:0]  sector_y;
        logic              last;
    } window_action_t;

    // fresh: nine loads around (tcx, tcy); same: no result at all
    typedef enum logic [1:0] {
        ROW_MODEL,
        ROW_SAME,
        ROW_FRESH,
        ROW_SIDE
    } row_kind_t;

    typedef struct packed {
        row_kind_t         kind;
        logic [SIDE_W-1:0] side;
        logic [POS_W-1:0]  px;
        logic [POS_W-1:0]  pz;
        logic [OUT_W-1:0]  tcx;
        logic [OUT_W-1:0]  tcy;
    } stim_row_t;

    localparam stim_row_t DIR_TABLE [DIR_ROWS] = '{
        '{ROW_FRESH, 24'd0, 32'h0000_0000, 32'h0000_0000, 32'h0000_0000, 32'h0000_0000},
        '{ROW_SAME,  24'd0, 32'h0000_0FFF, 32'h0000_0FFF, 32'h0000_0000, 32'h0000_0000},
        '{ROW_MODEL, 24'd0, 32'h0000_1000, 32'h0000_0000, 32'h0000_0000, 32'h0000_0000},
        '{ROW_MODEL, 24'd0, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'h0000_0000, 32'h0000_0000},
        '{ROW_MODEL, 24'd0, 32'hFFFF_F000, 32'hFFFF_EFFF, 32'h0000_0000, 32'h0000_0000},
        '{ROW_FRESH, 24'd0, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h0007_FFFF, 32'h0007_FFFF},
        '{ROW_FRESH, 24'd0, 32'h8000_0000, 32'h8000_0000, 32'hFFF8_0000, 32'hFFF8_0000},
        '{ROW_MODEL, 24'd0, 32'h7FFF_FFFF, 32'h8000_0000, 32'h0000_0000, 32'h0000_0000},
        '{ROW_SIDE,  24'd1, 32'h0000_0000, 32'h0000_0000, 32'h0000_0000, 32'h0000_0000},
        // neighbours of the most negative sector wrap to the most positive
        '{ROW_FRESH, 24'd0, 32'h8000_0000, 32'h8000_0000, 32'h8000_0000, 32'h8000_0000},
        '{ROW_MODEL, 24'd0, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h0000_0000, 32'h0000_0000},
        '{ROW_MODEL, 24'd0, 32'h7FFF_FFFF, 32'h8000_0000, 32'h0000_0000, 32'h0000_0000},
        '{ROW_SIDE,  24'hFF_FFFF, 32'h0, 32'h0, 32'h0, 32'h0},
        '{ROW_FRESH, 24'd0, 32'hFFFF_FFFF, 32'h0000_0000, 32'hFFFF_FFFF, 32'h0000_0000},
        '{ROW_MODEL, 24'd0, 32'h7FFF_FFFF, 32'h8000_0000, 32'h0000_0000, 32'h0000_0000},
        '{ROW_MODEL, 24'd0, 32'h00FF_FFFE, 32'hFF00_0001, 32'h0000_0000, 32'h0000_0000},
        // zero side acts as one
        '{ROW_SIDE,  24'd0, 32'h0000_0000, 32'h0000_0000, 32'h0000_0000, 32'h0000_0000},
        '{ROW_MODEL, 24'd0, 32'h0000_0005, 32'hFFFF_FFFB, 32'h0000_0000, 32'h0000_0000},
        '{ROW_SAME,  24'd0, 32'h0000_0005, 32'hFFFF_FFFB, 32'h0000_0000, 32'h0000_0000},
        '{ROW_MODEL, 24'd0, 32'h0000_0006, 32'hFFFF_FFFB, 32'h0000_0000, 32'h0000_0000},
        '{ROW_MODEL, 24'd0, 32'h0000_0004, 32'hFFFF_FFFC, 32'h0000_0000, 32'h0000_0000},
        '{ROW_SIDE,  24'd3, 32'h0000_0000, 32'h0000_0000, 32'h0000_0000, 32'h0000_0000},
        '{ROW_MODEL, 24'd0, 32'hFFFF_FFF9, 32'h0000_0007, 32'h0000_0000, 32'h0000_0000},
        '{ROW_MODEL, 24'd0, 32'hFFFF_FFFA, 32'h0000_0008, 32'h0000_0000, 32'h0000_0000},
        '{ROW_MODEL, 24'd0, 32'hFFFF_FFF8, 32'h0000_0006, 32'h0000_0000, 32'h0000_0000}
    };

    logic                     i_clk             = 1'b0;
    logic                     i_rst_n           = 1'b0;
    logic                     i_in_valid        = 1'b0;
    logic signed [POS_W-1:0]  i_pos_x           = '0;
    logic signed [POS_W-1:0]  i_pos_z           = '0;
    logic                     i_cfg_valid       = 1'b0;
    logic        [SIDE_W-1:0] i_cfg_sector_side = '0;
    logic                     i_out_ready       = 1'b0;
    logic                     o_in_ready;
    logic                     o_cfg_ready;
    logic                     o_out_valid;
    logic                     o_action;
    logic        [SLOT_W-1:0] o_slot_a;
    logic        [SLOT_W-1:0] o_slot_b;
    logic signed [OUT_W-1:0]  o_sector_x;
    logic signed [OUT_W-1:0]  o_sector_y;
    logic                     o_last;

    // predicted block state
    logic [SIDE_W-1:0] side_reg = SIDE_RESET;
    bit                slot_full [NUM_SLOTS] = '{default: 1'b0};
    logic [OUT_W-1:0]  slot_x [NUM_SLOTS] = '{default: '0};
    logic [OUT_W-1:0]  slot_y [NUM_SLOTS] = '{default: '0};
    logic [OUT_W-1:0]  cur_x = '0;
    logic [OUT_W-1:0]  cur_y = '0;
    bit                cur_valid = 1'b0;

    window_action_t pending_actions [$];
    int             mismatch_count = 0;
    int             cycle_count = 0;
    int             tx_idle_pct = 31;
    int             rx_idle_pct = 86;

    sector_window_slot_manager_core dut (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .i_in_valid        (i_in_valid),
        .o_in_ready        (o_in_ready),
        .i_pos_x           (i_pos_x),
        .i_pos_z           (i_pos_z),
        .i_cfg_valid       (i_cfg_valid),
        .o_cfg_ready       (o_cfg_ready),
        .i_cfg_sector_side (i_cfg_sector_side),
        .o_out_valid       (o_out_valid),
        .i_out_ready       (i_out_ready),
        .o_action          (o_action),
        .o_slot_a          (o_slot_a),
        .o_slot_b          (o_slot_b),
        .o_sector_x        (o_sector_x),
        .o_sector_y        (o_sector_y),
        .o_last            (o_last)
    );

    initial begin
        forever #2 i_clk = ~i_clk;
    end

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("tb_sector_window_slot_manager_core NOT OK");
            $finish;
        end
    end

    always @(posedge i_clk) begin
        i_out_ready <= ($urandom_range(0, 99) >= rx_idle_pct);
    end

    task automatic flag_mismatch(input string what, input logic [31:0] got,
                                 input logic [31:0] want);
        if (mismatch_count < MAX_PRINTS)
            $display("%0t: %s got %0h want %0h", $time, what, got, want);
        mismatch_count++;
    endtask

    // floor division by the side, exact for negative positions
    function automatic logic [OUT_W-1:0] sector_of(input logic signed [POS_W-1:0] p);
        longint num;
        longint den;
        longint q;
        num = p;
        den = side_reg;
        if (den == 0)
            den = 1;
        q = num / den;
        if ((num % den) != 0 && num < 0)
            q = q - 1;
        return q[OUT_W-1:0];
    endfunction

    task automatic refit_window(input logic signed [POS_W-1:0] px,
                                input logic signed [POS_W-1:0] pz, input bit keep);
        logic [OUT_W-1:0] cx;
        logic [OUT_W-1:0] cy;
        logic [OUT_W-1:0] wx;
        logic [OUT_W-1:0] wy;
        logic [OUT_W-1:0] tx;
        logic [OUT_W-1:0] ty;
        bit               tv;
        int               found;
        window_action_t   batch [$];
        cx = sector_of(px);
        cy = sector_of(pz);
        if (cur_valid && cx == cur_x && cy == cur_y)
            return;
        // pull each wanted sector into place, lowest holding slot first
        for (int i = 0; i < NUM_SLOTS; i++) begin
            wx = cx + 32'(i % 3) - 32'd1;
            wy = cy + 32'(i / 3) - 32'd1;
            found = -1;
            for (int j = 0; j < NUM_SLOTS; j++) begin
                if (found < 0 && slot_full[j] && slot_x[j] == wx && slot_y[j] == wy)
                    found = j;
            end
            if (found >= 0 && found != i) begin
                tv = slot_full[i];
                tx = slot_x[i];
                ty = slot_y[i];
                slot_full[i] = slot_full[found];
                slot_x[i] = slot_x[found];
                slot_y[i] = slot_y[found];
                slot_full[found] = tv;
                slot_x[found] = tx;
                slot_y[found] = ty;
                batch.push_back(window_action_t'{ACT_SWAP, 4'(i), 4'(found),
                                                 32'd0, 32'd0, 1'b0});
            end
        end
        for (int i = 0; i < NUM_SLOTS; i++) begin
            wx = cx + 32'(i % 3) - 32'd1;
            wy = cy + 32'(i / 3) - 32'd1;
            if (!slot_full[i] || slot_x[i] != wx || slot_y[i] != wy) begin
                slot_full[i] = 1'b1;
                slot_x[i] = wx;
                slot_y[i] = wy;
                batch.push_back(window_action_t'{ACT_LOAD, 4'(i), 4'd0, wx, wy, 1'b0});
            end
        end
        if (batch.size() > 0)
            batch[batch.size() - 1].last = 1'b1;
        if (keep) begin
            foreach (batch[k])
                pending_actions.push_back(batch[k]);
        end
        cur_x = cx;
        cur_y = cy;
        cur_valid = 1'b1;
    endtask

    task automatic send_pos(input logic signed [POS_W-1:0] px,
                            input logic signed [POS_W-1:0] pz, input row_kind_t kind,
                            input logic [OUT_W-1:0] tcx, input logic [OUT_W-1:0] tcy);
        if ($urandom_range(0, 99) < tx_idle_pct) begin
            i_in_valid <= 1'b0;
            do @(posedge i_clk); while ($urandom_range(0, 99) < tx_idle_pct);
        end
        i_in_valid <= 1'b1;
        i_pos_x <= px;
        i_pos_z <= pz;
        do @(posedge i_clk); while (!o_in_ready);
        refit_window(px, pz, kind == ROW_MODEL);
        if (kind == ROW_FRESH) begin
            for (int i = 0; i < NUM_SLOTS; i++)
                pending_actions.push_back(window_action_t'{ACT_LOAD, 4'(i), 4'd0,
                                                           tcx + 32'(i % 3) - 32'd1,
                                                           tcy + 32'(i / 3) - 32'd1,
                                                           i == NUM_SLOTS - 1});
        end
    endtask

    // stop sending until every expected item is out, then let the block settle
    task automatic drain(input int settle);
        i_in_valid <= 1'b0;
        do @(posedge i_clk); while (pending_actions.size() != 0);
        repeat (settle) @(posedge i_clk);
    endtask

    task automatic write_side(input logic [SIDE_W-1:0] value);
        drain(SETTLE_CYCLES);
        i_cfg_valid <= 1'b1;
        i_cfg_sector_side <= value;
        do @(posedge i_clk); while (!o_cfg_ready);
        i_cfg_valid <= 1'b0;
        side_reg = value;
    endtask

    always @(posedge i_clk) begin
        window_action_t want;
        if (i_rst_n && o_out_valid && i_out_ready) begin
            if (pending_actions.size() == 0) begin
                flag_mismatch("unexpected item, slot_a", 32'(o_slot_a), 32'd0);
            end else begin
                want = pending_actions.pop_front();
                if (o_action !== want.action)
                    flag_mismatch("action", 32'(o_action), 32'(want.action));
                if (o_slot_a !== want.slot_a)
                    flag_mismatch("slot_a", 32'(o_slot_a), 32'(want.slot_a));
                if (o_slot_b !== want.slot_b)
                    flag_mismatch("slot_b", 32'(o_slot_b), 32'(want.slot_b));
                if (o_sector_x !== want.sector_x)
                    flag_mismatch("sector_x", o_sector_x, want.sector_x);
                if (o_sector_y !== want.sector_y)
                    flag_mismatch("sector_y", o_sector_y, want.sector_y);
                if (o_last !== want.last)
                    flag_mismatch("last", 32'(o_last), 32'(want.last));
            end
        end
    end

    initial begin
        int                      s;
        int                      delta;
        int                      pick;
        longint                  k;
        logic signed [POS_W-1:0] walk_x;
        logic signed [POS_W-1:0] walk_z;

        walk_x = '0;
        walk_z = '0;
        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;

        foreach (DIR_TABLE[r]) begin
            if (DIR_TABLE[r].kind == ROW_SIDE)
                write_side(DIR_TABLE[r].side);
            else
                send_pos(DIR_TABLE[r].px, DIR_TABLE[r].pz, DIR_TABLE[r].kind,
                         DIR_TABLE[r].tcx, DIR_TABLE[r].tcy);
        end

        for (int ph = 0; ph < 3; ph++) begin
            case (ph)
                0: write_side(24'($urandom_range(1, 64)));
                1: write_side(24'($urandom_range(1, 24'hFF_FFFF)));
                default: write_side(24'($urandom_range(256, 8192)));
            endcase
            case (ph)
                0: begin
                    tx_idle_pct = 31;
                    rx_idle_pct = 86;
                end
                1: begin
                    tx_idle_pct = 86;
                    rx_idle_pct = 31;
                end
                default: begin
                    tx_idle_pct = 0;
                    rx_idle_pct = 0;
                end
            endcase
            s = (side_reg == 0) ? 1 : int'(side_reg);
            for (int n = 0; n < PHASE_ITEMS; n++) begin
                if (ph == 0 && n == PHASE_ITEMS / 2)
                    drain(0);
                pick = $urandom_range(0, 99);
                if (pick < 10) begin
                    // same position again, no re-fit
                end else if (pick < 20) begin
                    walk_x = $urandom;
                    walk_z = $urandom;
                end else if (pick < 30) begin
                    // land on or just below a sector edge
                    k = longint'(walk_x) / s;
                    walk_x = 32'(k * s - longint'($urandom_range(0, 1)));
                    k = longint'(walk_z) / s;
                    walk_z = 32'(k * s - longint'($urandom_range(0, 1)));
                end else begin
                    delta = int'($urandom_range(0, 4 * s)) - 2 * s;
                    walk_x = walk_x + delta;
                    delta = int'($urandom_range(0, 4 * s)) - 2 * s;
                    walk_z = walk_z + delta;
                end
                send_pos(walk_x, walk_z, ROW_MODEL, '0, '0);
            end
        end

        drain(SETTLE_CYCLES);
        if (mismatch_count == 0)
            $display("tb_sector_window_slot_manager_core OK");
        else
            $display("tb_sector_window_slot_manager_core NOT OK");
        $finish;
    end

endmodule
